FILE: hdl/sdpt_pkg.sv
// ----------------------------------------------------------------------------
// sdpt_pkg
// Shared types and constants for the step/direction position tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package sdpt_pkg;

  // Fixed widths of the stream fields and configuration registers
  localparam int LIMIT_BITS   = 24;
  localparam int LINE_BITS    = 4;
  localparam int OUT_AXES     = 4;
  localparam int OUT_POS_BITS = 24;
  localparam int S_DATA_BITS  = 8;
  localparam int M_DATA_BITS  = 112;
  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_X_LOW    = 3'd0,
    REG_X_HIGH   = 3'd1,
    REG_Y_LOW    = 3'd2,
    REG_Y_HIGH   = 3'd3,
    REG_STEP_INV = 3'd4,
    REG_DIR_INV  = 3'd5,
    REG_RSVD6    = 3'd6,
    REG_RSVD7    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [LIMIT_BITS-1:0] x_low;
    logic signed [LIMIT_BITS-1:0] x_high;
    logic signed [LIMIT_BITS-1:0] y_low;
    logic signed [LIMIT_BITS-1:0] y_high;
    logic [LINE_BITS-1:0]         step_inv;
    logic [LINE_BITS-1:0]         dir_inv;
  } sdpt_cfg_t;

  // Settings seen by one axis lane
  typedef struct packed {
    logic                         step_inv;
    logic                         dir_inv;
    logic signed [LIMIT_BITS-1:0] low;
    logic signed [LIMIT_BITS-1:0] high;
  } axis_cfg_t;

  // Status produced by one axis lane
  typedef struct packed {
    logic taken;
    logic rev_hit;
    logic fwd_hit;
  } axis_flags_t;

endpackage

`default_nettype wire

FILE: hdl/step_dir_position_tracker.sv
// ----------------------------------------------------------------------------
// step_dir_position_tracker
// Position counters for AXES step/direction driven motor axes.
// ----------------------------------------------------------------------------
// Each transaction on the slave stream carries one new level of every step and
// direction line. A step line change away from the axis's idle level (step
// invert mask) counts one step; the direction line, compared with the
// direction invert mask, picks -1 or +1. The moved position is clamped to the
// axis limits (even axes use the X pair, odd axes the Y pair; with crossed
// limits the axis lands on the high limit) and saturated to POSITION_BITS. A
// newly written limit does not move an axis until it steps, but the limit
// flags compare against it at once. Every input transaction yields exactly one
// output transaction with all positions, a step-taken flag and the per-axis
// reverse/forward limit flags. The block takes one transaction per clock while
// the master stream is not stalled; an accepted input is held in the input
// register, then the lane logic writes its result into the result register,
// which presents it on the master stream. Each lane updates its position
// register as the result register is loaded.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module step_dir_position_tracker
  import sdpt_pkg::*;
#(
  parameter int AXES          = 4,
  parameter int POSITION_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // APB configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  // Slave stream
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [S_DATA_BITS-1:0]   s_tdata,  // [3:0] step_lines, [7:4] dir_lines
  // Master stream
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // [23:0] axis0_position, [47:24] axis1_position, [71:48] axis2_position,
  // [95:72] axis3_position, [96] step_taken, [100:97] reverse_limit_hit,
  // [104:101] forward_limit_hit, [111:105] zero
  output logic [M_DATA_BITS-1:0]        m_tdata
);

  localparam int FLAG_BASE = OUT_AXES * OUT_POS_BITS;

  sdpt_cfg_t cfg;

  sdpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register
  logic                 in_valid;
  logic [LINE_BITS-1:0] in_step;
  logic [LINE_BITS-1:0] in_dir;
  logic                 advance;
  logic                 accept;

  // Move the held item into the result register when that register is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_step <= s_tdata[LINE_BITS-1:0];
      in_dir  <= s_tdata[2*LINE_BITS-1:LINE_BITS];
    end
  end

  // Per-axis lanes; axes beyond the line width never see a step
  logic [AXES-1:0]         lane_step;
  logic [AXES-1:0]         lane_dir;
  logic [AXES-1:0]         last_step;
  logic [AXES-1:0]         last_step_next;
  logic [AXES-1:0]         lane_taken;
  logic [OUT_AXES-1:0]     rev_next;
  logic [OUT_AXES-1:0]     fwd_next;
  logic [FLAG_BASE-1:0]    pos_field_next;
  axis_cfg_t               acfg       [AXES];
  axis_flags_t             lane_flags [AXES];
  logic signed [POSITION_BITS-1:0] lane_pos [AXES];

  for (genvar i = 0; i < AXES; i++) begin : g_axis
    if (i < LINE_BITS) begin : g_line
      assign lane_step[i]     = in_step[i];
      assign lane_dir[i]      = in_dir[i];
      assign acfg[i].step_inv = cfg.step_inv[i];
      assign acfg[i].dir_inv  = cfg.dir_inv[i];
    end else begin : g_noline
      assign lane_step[i]     = 1'b0;
      assign lane_dir[i]      = 1'b0;
      assign acfg[i].step_inv = 1'b0;
      assign acfg[i].dir_inv  = 1'b0;
    end

    if (i % 2 == 1) begin : g_odd
      assign acfg[i].low  = cfg.y_low;
      assign acfg[i].high = cfg.y_high;
    end else begin : g_even
      assign acfg[i].low  = cfg.x_low;
      assign acfg[i].high = cfg.x_high;
    end

    sdpt_axis #(
      .POSITION_BITS (POSITION_BITS)
    ) u_axis (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .step_new (lane_step[i]),
      .step_old (last_step[i]),
      .dir      (lane_dir[i]),
      .acfg     (acfg[i]),
      .pos_next (lane_pos[i]),
      .flags    (lane_flags[i])
    );

    assign lane_taken[i] = lane_flags[i].taken;
  end

  // Pack the reported axes; missing axes report zero
  for (genvar j = 0; j < OUT_AXES; j++) begin : g_out
    if (j < AXES) begin : g_used
      if (POSITION_BITS >= OUT_POS_BITS) begin : g_trunc
        assign pos_field_next[j*OUT_POS_BITS +: OUT_POS_BITS] =
          lane_pos[j][OUT_POS_BITS-1:0];
      end else begin : g_sext
        assign pos_field_next[j*OUT_POS_BITS +: OUT_POS_BITS] =
          {{(OUT_POS_BITS-POSITION_BITS){lane_pos[j][POSITION_BITS-1]}}, lane_pos[j]};
      end
      assign rev_next[j] = lane_flags[j].rev_hit;
      assign fwd_next[j] = lane_flags[j].fwd_hit;
    end else begin : g_unused
      assign pos_field_next[j*OUT_POS_BITS +: OUT_POS_BITS] = '0;
      assign rev_next[j] = 1'b0;
      assign fwd_next[j] = 1'b0;
    end
  end

  assign last_step_next = lane_step;

  // Step line history
  always_ff @(posedge clk) begin
    if (rst) begin
      last_step <= '0;
    end else if (advance) begin
      last_step <= last_step_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(M_DATA_BITS-FLAG_BASE-1-2*OUT_AXES){1'b0}},
                  fwd_next, rev_next, |lane_taken, pos_field_next};
    end
  end

  // An empty input register always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input register empty but s_tready low");

  // Step history moves only with an item
  a_history_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(last_step))
    else $error("step history changed without an item");

  // No step line change means no step reported
  a_no_change_no_step: assert property (@(posedge clk) disable iff (rst)
    (advance && (lane_step == last_step)) |=> !m_tdata[FLAG_BASE])
    else $error("step_taken set without a step line change");

  // A loaded result is valid on the next cycle
  a_result_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result register loaded but m_tvalid low");

endmodule

`default_nettype wire

FILE: hdl/sdpt_regs.sv
// ----------------------------------------------------------------------------
// sdpt_regs
// APB register file holding the axis limits and the line polarity masks.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpt_regs
  import sdpt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  output sdpt_cfg_t                     cfg
);

  reg_index_t idx;
  logic       wr_en;

  assign idx    = reg_index_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_low    <= '0;
      cfg.x_high   <= {1'b0, {(LIMIT_BITS-1){1'b1}}};
      cfg.y_low    <= '0;
      cfg.y_high   <= {1'b0, {(LIMIT_BITS-1){1'b1}}};
      cfg.step_inv <= '0;
      cfg.dir_inv  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_X_LOW:    cfg.x_low    <= pwdata[LIMIT_BITS-1:0];
        REG_X_HIGH:   cfg.x_high   <= pwdata[LIMIT_BITS-1:0];
        REG_Y_LOW:    cfg.y_low    <= pwdata[LIMIT_BITS-1:0];
        REG_Y_HIGH:   cfg.y_high   <= pwdata[LIMIT_BITS-1:0];
        REG_STEP_INV: cfg.step_inv <= pwdata[LINE_BITS-1:0];
        REG_DIR_INV:  cfg.dir_inv  <= pwdata[LINE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Limits read back sign-extended, masks zero-extended
  always_comb begin
    unique case (idx)
      REG_X_LOW:    prdata = APB_DATA_BITS'(cfg.x_low);
      REG_X_HIGH:   prdata = APB_DATA_BITS'(cfg.x_high);
      REG_Y_LOW:    prdata = APB_DATA_BITS'(cfg.y_low);
      REG_Y_HIGH:   prdata = APB_DATA_BITS'(cfg.y_high);
      REG_STEP_INV: prdata = {{(APB_DATA_BITS-LINE_BITS){1'b0}}, cfg.step_inv};
      REG_DIR_INV:  prdata = {{(APB_DATA_BITS-LINE_BITS){1'b0}}, cfg.dir_inv};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/sdpt_axis.sv
// ----------------------------------------------------------------------------
// sdpt_axis
// One axis lane: position register, step detection, move, clamp and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpt_axis
  import sdpt_pkg::*;
#(
  parameter int POSITION_BITS = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             advance,
  input  wire logic                             step_new,
  input  wire logic                             step_old,
  input  wire logic                             dir,
  input  axis_cfg_t                             acfg,
  output logic signed [POSITION_BITS-1:0]       pos_next,
  output axis_flags_t                           flags
);

  localparam int CW = ((POSITION_BITS > LIMIT_BITS) ? POSITION_BITS : LIMIT_BITS) + 2;
  localparam logic signed [CW-1:0] POS_MAX =
    {{(CW-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [CW-1:0] POS_MIN =
    {{(CW-POSITION_BITS+1){1'b1}}, {(POSITION_BITS-1){1'b0}}};

  logic signed [POSITION_BITS-1:0] pos;
  logic signed [CW-1:0] cur_w, lo_w, hi_w, moved, clamp_lo, clamp_hi, sat, upd_w;
  logic counted;

  assign counted = (step_new != step_old) && (step_new != acfg.step_inv);
  assign cur_w   = CW'(pos);
  assign lo_w    = CW'($signed(acfg.low));
  assign hi_w    = CW'($signed(acfg.high));

  always_comb begin
    moved    = (dir == acfg.dir_inv) ? cur_w - CW'(1) : cur_w + CW'(1);
    // Raise to the low limit first, then lower to the high limit
    clamp_lo = (moved < lo_w) ? lo_w : moved;
    clamp_hi = (clamp_lo > hi_w) ? hi_w : clamp_lo;
    sat      = (clamp_hi > POS_MAX) ? POS_MAX :
               (clamp_hi < POS_MIN) ? POS_MIN : clamp_hi;
    upd_w    = counted ? sat : cur_w;
  end

  assign pos_next      = upd_w[POSITION_BITS-1:0];
  assign flags.taken   = counted;
  assign flags.rev_hit = (upd_w <= lo_w);
  assign flags.fwd_hit = (upd_w >= hi_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (advance && counted) begin
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

FILE: sim/step_dir_position_tracker_tb.sv
// ----------------------------------------------------------------------------
// step_dir_position_tracker_tb
// Self-checking bench for the four-axis step/direction position tracker.
// ----------------------------------------------------------------------------
// Line updates go in on the slave stream. A behavioral copy of the tracker
// predicts one position report per accepted update, and the report on the
// master stream is compared field by field. Directed updates cover idle and
// counting edges, both invert masks, crossed, narrow and extreme limits and
// the reserved register addresses. Random motion then runs under four idle
// mixes with fresh register settings, plus a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module step_dir_position_tracker_tb
  import sdpt_pkg::*;
();

  localparam int     AXES            = 4;
  localparam int     POS_BITS        = 24;
  localparam longint POS_MAX         = (longint'(1) << (POS_BITS - 1)) - 1;
  localparam longint POS_MIN         = -(longint'(1) << (POS_BITS - 1));
  localparam int     RESET_CYCLES    = 9;
  // Margin after the last report before the block counts as idle
  localparam int     SETTLE_CYCLES   = 4;
  localparam int     QUIET_LIMIT     = 2000;
  localparam int     HOLD_OFF_CYCLES = 200;
  localparam int     PHASE_ITEMS     = 330;

  // Same bit order as m_tdata[104:0]: axis 0 position in the lowest bits
  typedef struct packed {
    logic [OUT_AXES-1:0]                   fwd;
    logic [OUT_AXES-1:0]                   rev;
    logic                                  taken;
    logic [OUT_AXES-1:0][OUT_POS_BITS-1:0] pos;
  } position_report_t;

  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     psel     = 1'b0;
  logic                     penable  = 1'b0;
  logic                     pwrite   = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr    = '0;
  logic [APB_DATA_BITS-1:0] pwdata   = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [S_DATA_BITS-1:0]   s_tdata  = '0;   // [3:0] step_lines, [7:4] dir_lines
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  // [23:0] axis0_position, [47:24] axis1_position, [71:48] axis2_position,
  // [95:72] axis3_position, [96] step_taken, [100:97] reverse_limit_hit,
  // [104:101] forward_limit_hit, [111:105] zero
  logic [M_DATA_BITS-1:0]   m_tdata;

  // Shadow of the register file and of the tracker state
  sdpt_cfg_t                   shadow;
  logic signed [POS_BITS-1:0]  axis_pos [AXES];
  logic [LINE_BITS-1:0]        step_level;
  logic [LINE_BITS-1:0]        dir_level;

  position_report_t predicted_reports [$];

  int src_idle_pct    = 0;
  int sink_stall_pct  = 0;
  int hold_off        = 0;
  int items_sent      = 0;
  int reports_checked = 0;
  int register_writes = 0;
  int mismatches      = 0;

  step_dir_position_tracker DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Advance the shadow tracker by one line update and build its report.
  function automatic position_report_t predict_positions(input logic [LINE_BITS-1:0] st,
                                                         input logic [LINE_BITS-1:0] dr);
    position_report_t r;
    longint           lo;
    longint           hi;
    longint           np;
    r = '0;
    for (int a = 0; a < AXES; a++) begin
      // Even axes follow the X pair, odd axes the Y pair
      lo = (a % 2) ? longint'(shadow.y_low)  : longint'(shadow.x_low);
      hi = (a % 2) ? longint'(shadow.y_high) : longint'(shadow.x_high);
      // Count only a change that moves away from the idle level
      if (st[a] != step_level[a] && st[a] != shadow.step_inv[a]) begin
        np = axis_pos[a];
        np = (dr[a] == shadow.dir_inv[a]) ? np - 1 : np + 1;
        // Low first, then high: crossed limits end on the high limit
        if (np < lo) np = lo;
        if (np > hi) np = hi;
        if (np > POS_MAX) np = POS_MAX;
        if (np < POS_MIN) np = POS_MIN;
        axis_pos[a] = np[POS_BITS-1:0];
        r.taken     = 1'b1;
      end
      // Flags always compare the stored position, even one left outside
      // freshly written limits
      r.pos[a] = axis_pos[a];
      r.rev[a] = (longint'(axis_pos[a]) <= lo);
      r.fwd[a] = (longint'(axis_pos[a]) >= hi);
    end
    step_level = st;
    dir_level  = dr;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input longint want, input longint seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endtask

  // Compare every accepted report with the oldest prediction.
  always @(posedge clk) begin : check_reports
    position_report_t got;
    position_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[104:0];
      if (predicted_reports.size() == 0) begin
        $error("position report with no update pending: %h", m_tdata);
        mismatches++;
      end else begin
        want = predicted_reports.pop_front();
        for (int a = 0; a < AXES; a++) begin
          check_field($sformatf("axis%0d_position", a),
                      $signed(want.pos[a]), $signed(got.pos[a]));
        end
        check_field("step_taken", want.taken, got.taken);
        check_field("reverse_limit_hit", want.rev, got.rev);
        check_field("forward_limit_hit", want.fwd, got.fwd);
        check_field("padding", 0, m_tdata[M_DATA_BITS-1:105]);
        reports_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off while hold_off counts down
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off = hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // End the run when neither stream nor the register port moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet = 0;
      else quiet++;
    end
    $error("no transaction for %0d cycles", QUIET_LIMIT);
    $display("step_dir_position_tracker_tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks; all of them start and end just after a falling edge
  // --------------------------------------------------------------------------

  // Offer one line update and predict its report once the transaction is taken.
  task automatic send_lines(input logic [LINE_BITS-1:0] st, input logic [LINE_BITS-1:0] dr);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {dr, st};
    do @(posedge clk); while (!s_tready);
    predicted_reports = {predicted_reports, predict_positions(st, dr)};
    items_sent++;
    @(negedge clk);
  endtask

  // Mostly plausible motion: toggle some step lines, keep direction steady.
  task automatic send_motion();
    logic [LINE_BITS-1:0] st;
    logic [LINE_BITS-1:0] dr;
    if ($urandom_range(9) < 7) begin
      st = step_level ^ 4'($urandom_range(15));
      dr = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : dir_level;
    end else begin
      st = 4'($urandom);
      dr = 4'($urandom);
    end
    send_lines(st, dr);
  endtask

  // Drop valid and hold until every predicted report has come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (predicted_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup phase, then access phase; only with the block idle.
  task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_BITS-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_X_LOW:    shadow.x_low    = value[LIMIT_BITS-1:0];
      REG_X_HIGH:   shadow.x_high   = value[LIMIT_BITS-1:0];
      REG_Y_LOW:    shadow.y_low    = value[LIMIT_BITS-1:0];
      REG_Y_HIGH:   shadow.y_high   = value[LIMIT_BITS-1:0];
      REG_STEP_INV: shadow.step_inv = value[LINE_BITS-1:0];
      REG_DIR_INV:  shadow.dir_inv  = value[LINE_BITS-1:0];
      default: ;
    endcase
    register_writes++;
  endtask

  // Pick one limit pair: full range, crossed, pinned at an extreme, arbitrary,
  // or a narrow window near zero where the axes actually hit the limits.
  task automatic choose_limits(output logic [LIMIT_BITS-1:0] lo,
                               output logic [LIMIT_BITS-1:0] hi);
    int base;
    case ($urandom_range(5))
      0: begin
        lo = 24'h800000;
        hi = 24'h7FFFFF;
      end
      1: begin
        base = $urandom_range(30);
        lo   = 24'(base);
        hi   = 24'(base - int'($urandom_range(30, 1)));
      end
      2: begin
        lo = ($urandom_range(1) != 0) ? 24'h7FFFFF : 24'h800000;
        hi = lo;
      end
      3: begin
        lo = 24'($urandom);
        hi = 24'($urandom);
      end
      default: begin
        base = int'($urandom_range(40)) - 30;
        lo   = 24'(base);
        hi   = 24'(base + int'($urandom_range(40)));
      end
    endcase
  endtask

  // Rewrite every register; junk in the unused upper bits must be ignored.
  task automatic randomize_setup();
    logic [LIMIT_BITS-1:0] lo;
    logic [LIMIT_BITS-1:0] hi;
    choose_limits(lo, hi);
    write_reg(REG_X_LOW,  {8'($urandom), lo});
    write_reg(REG_X_HIGH, {8'($urandom), hi});
    choose_limits(lo, hi);
    write_reg(REG_Y_LOW,  {8'($urandom), lo});
    write_reg(REG_Y_HIGH, {8'($urandom), hi});
    write_reg(REG_STEP_INV, $urandom);
    write_reg(REG_DIR_INV,  $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset limits are 0..max, so a negative step from zero is held at zero.
  task automatic test_default_limits();
    send_lines(4'hF, 4'h0);   // all axes step down, clamp at the low limit
    send_lines(4'h0, 4'hF);   // back to the idle level: no count
    send_lines(4'hF, 4'hF);   // all axes step up
    send_lines(4'hF, 4'hF);   // same level again: no count
    send_lines(4'h0, 4'hF);
    send_lines(4'h5, 4'hF);   // even axes only
  endtask

  // Idle-high step lines count falling edges; a high direction line means down.
  task automatic test_inverted_lines();
    write_reg(REG_STEP_INV, 32'hF);
    write_reg(REG_DIR_INV,  32'hF);
    send_lines(4'h0, 4'hF);   // even axes fall away from idle, move down
    send_lines(4'hF, 4'h0);   // rise to idle: no count
    send_lines(4'h0, 4'h0);   // all axes fall, move up
    send_lines(4'hF, 4'hF);
  endtask

  // Narrow, crossed and extreme limits, and positions left outside new limits.
  task automatic test_limit_cases();
    write_reg(REG_STEP_INV, 32'h0);
    write_reg(REG_DIR_INV,  32'h0);
    send_lines(4'h0, 4'h0);
    // Pin the even axes at 5; flags see the new pair before any step
    write_reg(REG_X_LOW,  32'd5);
    write_reg(REG_X_HIGH, 32'd5);
    send_lines(4'h0, 4'h0);
    send_lines(4'h5, 4'h0);   // step down, pulled up to 5
    // Crossed pair on the odd axes: a step lands on the high limit
    write_reg(REG_Y_LOW,  32'd100);
    write_reg(REG_Y_HIGH, 32'(-100));
    send_lines(4'h0, 4'h0);
    send_lines(4'hA, 4'hF);
    // Even axes pinned at the most negative value, odd axes at the most positive
    write_reg(REG_X_LOW,  32'hFF80_0000);
    write_reg(REG_X_HIGH, 32'hFF80_0000);
    write_reg(REG_Y_LOW,  32'h007F_FFFF);
    write_reg(REG_Y_HIGH, 32'h007F_FFFF);
    send_lines(4'h0, 4'h0);
    send_lines(4'hF, 4'hF);
    // Full range: stepping past either end saturates
    write_reg(REG_X_HIGH, 32'h007F_FFFF);
    write_reg(REG_Y_LOW,  32'hFF80_0000);
    send_lines(4'h0, 4'h0);
    send_lines(4'h5, 4'h0);   // even axes below the minimum
    send_lines(4'h0, 4'h0);
    send_lines(4'hA, 4'hF);   // odd axes above the maximum
  endtask

  // Writes to the two spare addresses must change nothing.
  task automatic test_reserved_registers();
    write_reg(REG_RSVD6, $urandom);
    write_reg(REG_RSVD7, $urandom);
    send_motion();
    send_motion();
  endtask

  // Hold the receiver off while updates keep coming, so the input stalls;
  // then pause the sender until every report is back.
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_off       = HOLD_OFF_CYCLES;
    repeat (40) send_motion();
    wait_idle();
    repeat (20) send_motion();
  endtask

  // Random motion under four idle mixes, with two register settings each.
  task automatic test_random_traffic();
    int src_mix  [4] = '{0, 83, 0, 32};
    int sink_mix [4] = '{0, 0, 83, 32};
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_mix[p];
      sink_stall_pct = sink_mix[p];
      randomize_setup();
      repeat (PHASE_ITEMS / 2) send_motion();
      randomize_setup();
      repeat (PHASE_ITEMS / 2) send_motion();
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    shadow.x_low    = '0;
    shadow.x_high   = 24'h7FFFFF;
    shadow.y_low    = '0;
    shadow.y_high   = 24'h7FFFFF;
    shadow.step_inv = '0;
    shadow.dir_inv  = '0;
    for (int a = 0; a < AXES; a++) axis_pos[a] = '0;
    step_level = '0;
    dir_level  = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_limits();
    test_inverted_lines();
    test_limit_cases();
    test_reserved_registers();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    $display("%0d line updates sent, %0d position reports checked, %0d register writes",
             items_sent, reports_checked, register_writes);
    $display("covered idle/counting edges, invert masks, crossed and extreme limits, %s",
             "spare addresses, a long output hold-off and four idle mixes");
    if (mismatches == 0) begin
      $display("step_dir_position_tracker_tb: PASS");
    end else begin
      $display("step_dir_position_tracker_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
